### hdl/y86_execute_stage_defines.svh
// Assertion macros for the Y86-64 execute stage.
`ifndef Y86_EXECUTE_STAGE_DEFINES_SVH
`define Y86_EXECUTE_STAGE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property on aclk, disabled while reset is asserted.
`define Y86_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked property on aclk that stays active through reset.
`define Y86_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define Y86_ASSERT(name, prop, msg)
`define Y86_ASSERT_RST(name, prop, msg)
`endif

`endif

### hdl/y86ex_pkg.sv
// Opcode, ALU function and condition codes for the Y86-64 execute stage.
package y86ex_pkg;

    localparam int unsigned DATA_W = 64;

    // Instruction codes.
    localparam logic [3:0] OP_CMOV  = 4'd2;
    localparam logic [3:0] OP_IRMOV = 4'd3;
    localparam logic [3:0] OP_RMMOV = 4'd4;
    localparam logic [3:0] OP_MRMOV = 4'd5;
    localparam logic [3:0] OP_OPQ   = 4'd6;
    localparam logic [3:0] OP_JXX   = 4'd7;
    localparam logic [3:0] OP_CALL  = 4'd8;
    localparam logic [3:0] OP_RET   = 4'd9;
    localparam logic [3:0] OP_PUSH  = 4'd10;
    localparam logic [3:0] OP_POP   = 4'd11;
    localparam logic [3:0] OP_IADD  = 4'd12;

    // ALU functions.
    localparam logic [3:0] ALU_ADD = 4'd0;
    localparam logic [3:0] ALU_SUB = 4'd1;
    localparam logic [3:0] ALU_AND = 4'd2;
    localparam logic [3:0] ALU_XOR = 4'd3;

    // Condition codes.
    localparam logic [3:0] COND_ALWAYS = 4'd0;
    localparam logic [3:0] COND_LE     = 4'd1;
    localparam logic [3:0] COND_L      = 4'd2;
    localparam logic [3:0] COND_E      = 4'd3;
    localparam logic [3:0] COND_NE     = 4'd4;
    localparam logic [3:0] COND_GE     = 4'd5;
    localparam logic [3:0] COND_G      = 4'd6;

    localparam logic [3:0] REG_NONE = 4'd15;

    localparam logic [DATA_W-1:0] STACK_UP   = 64'd8;
    localparam logic [DATA_W-1:0] STACK_DOWN = 64'hFFFF_FFFF_FFFF_FFF8;

endpackage

### hdl/y86_execute_stage.sv
// Y86-64 pipeline execute stage: ALU, condition flags and condition test.
//
// Usage: decoded instructions enter on the s_ channel (valid/ready) and one
// result per item leaves on the m_ channel (valid/ready). Each item is first
// captured in an input register; the ALU, flag update and condition test then
// run in one pass of combinational logic into the result register.
// Throughput: one item per cycle while the receiver keeps m_ready high. The
// zero, sign and overflow flags are updated in the same cycle an item moves
// into the result register, so the next item sees them at once; this flag
// loop and the 64-bit adder set the cycle.
// When the receiver stalls, the result register holds and the input register
// can still take one more item; after that s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous) empties both registers and sets the flags
// to ZF=1, SF=0, OF=0.
`include "y86_execute_stage_defines.svh"

module y86_execute_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_opcode,
    input  logic [3:0]         s_func_code,
    input  logic signed [63:0] s_operand_a,
    input  logic signed [63:0] s_operand_b,
    input  logic signed [63:0] s_constant_c,
    input  logic [3:0]         s_dest_reg_e,
    input  logic               s_is_bubble,
    input  logic               s_later_exception,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_alu_result,
    output logic               m_cond_true,
    output logic [3:0]         m_dest_reg_out,
    output logic               m_zero_flag,
    output logic               m_sign_flag,
    output logic               m_overflow_flag
);

    // Input register.
    logic        in_valid_reg;
    logic [3:0]  opcode_reg;
    logic [3:0]  func_reg;
    logic [63:0] operand_a_reg;
    logic [63:0] operand_b_reg;
    logic [63:0] constant_c_reg;
    logic [3:0]  dest_reg;
    logic        bubble_reg;
    logic        later_exc_reg;

    // Flags and result register.
    logic        zf_reg, sf_reg, of_reg;
    logic        zf_next, sf_next, of_next;
    logic        m_valid_reg;
    logic [63:0] alu_result_reg, alu_result_next;
    logic        cond_reg, cond_next;
    logic [3:0]  dest_out_reg, dest_out_next;

    logic        advance;
    logic [63:0] alu_a, alu_b, sum;
    logic [3:0]  alu_fn;
    logic        is_sub;
    logic        set_flags;
    logic        lt, eq;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        case (opcode_reg)
            y86ex_pkg::OP_CMOV, y86ex_pkg::OP_OPQ: begin
                alu_a = operand_a_reg;
            end
            y86ex_pkg::OP_IRMOV, y86ex_pkg::OP_RMMOV, y86ex_pkg::OP_MRMOV,
            y86ex_pkg::OP_JXX, y86ex_pkg::OP_IADD: begin
                alu_a = constant_c_reg;
            end
            y86ex_pkg::OP_CALL, y86ex_pkg::OP_PUSH: begin
                alu_a = y86ex_pkg::STACK_DOWN;
            end
            y86ex_pkg::OP_RET, y86ex_pkg::OP_POP: begin
                alu_a = y86ex_pkg::STACK_UP;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    always_comb begin
        case (opcode_reg)
            y86ex_pkg::OP_RMMOV, y86ex_pkg::OP_MRMOV, y86ex_pkg::OP_OPQ,
            y86ex_pkg::OP_CALL, y86ex_pkg::OP_RET, y86ex_pkg::OP_PUSH,
            y86ex_pkg::OP_POP, y86ex_pkg::OP_IADD: begin
                alu_b = operand_b_reg;
            end
            default: begin
                alu_b = '0;
            end
        endcase
    end

    // One adder serves both add and subtract (B minus A).
    assign alu_fn = (opcode_reg == y86ex_pkg::OP_OPQ) ? func_reg : y86ex_pkg::ALU_ADD;
    assign is_sub = (alu_fn == y86ex_pkg::ALU_SUB);
    assign sum    = alu_b + (alu_a ^ {64{is_sub}}) + {63'd0, is_sub};

    assign set_flags = !bubble_reg && !later_exc_reg &&
                       ((opcode_reg == y86ex_pkg::OP_OPQ) ||
                        (opcode_reg == y86ex_pkg::OP_IADD));

    always_comb begin
        logic [63:0] r;
        r = '0;
        case (alu_fn)
            y86ex_pkg::ALU_ADD: r = sum;
            y86ex_pkg::ALU_SUB: r = sum;
            y86ex_pkg::ALU_AND: r = alu_b & alu_a;
            y86ex_pkg::ALU_XOR: r = alu_b ^ alu_a;
            default:            r = '0;
        endcase

        zf_next = zf_reg;
        sf_next = sf_reg;
        of_next = of_reg;
        if (set_flags) begin
            zf_next = (r == '0);
            sf_next = r[63];
            case (alu_fn)
                y86ex_pkg::ALU_ADD: of_next = (alu_a[63] == alu_b[63]) && (r[63] != alu_a[63]);
                y86ex_pkg::ALU_SUB: of_next = (alu_a[63] != alu_b[63]) && (r[63] != alu_b[63]);
                default:            of_next = 1'b0;
            endcase
        end

        // The condition is tested against the flags as they stand after this item.
        lt = sf_next ^ of_next;
        eq = zf_next;
        case (func_reg)
            y86ex_pkg::COND_ALWAYS: cond_next = 1'b1;
            y86ex_pkg::COND_LE:     cond_next = lt || eq;
            y86ex_pkg::COND_L:      cond_next = lt;
            y86ex_pkg::COND_E:      cond_next = eq;
            y86ex_pkg::COND_NE:     cond_next = !eq;
            y86ex_pkg::COND_GE:     cond_next = !lt;
            y86ex_pkg::COND_G:      cond_next = !lt && !eq;
            default:                cond_next = 1'b0;
        endcase

        alu_result_next = r;
        dest_out_next   = dest_reg;
        if ((opcode_reg == y86ex_pkg::OP_CMOV) && !cond_next) begin
            dest_out_next = y86ex_pkg::REG_NONE;
        end
        if (bubble_reg) begin
            alu_result_next = '0;
            cond_next       = 1'b0;
            dest_out_next   = y86ex_pkg::REG_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            zf_reg       <= 1'b1;
            sf_reg       <= 1'b0;
            of_reg       <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                zf_reg      <= zf_next;
                sf_reg      <= sf_next;
                of_reg      <= of_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            opcode_reg     <= s_opcode;
            func_reg       <= s_func_code;
            operand_a_reg  <= s_operand_a;
            operand_b_reg  <= s_operand_b;
            constant_c_reg <= s_constant_c;
            dest_reg       <= s_dest_reg_e;
            bubble_reg     <= s_is_bubble;
            later_exc_reg  <= s_later_exception;
        end
        if (advance) begin
            alu_result_reg <= alu_result_next;
            cond_reg       <= cond_next;
            dest_out_reg   <= dest_out_next;
        end
    end

    // The flag outputs are the flag registers, which change only at reset or as an item
    // moves into the result register.
    assign m_valid         = m_valid_reg;
    assign m_alu_result    = $signed(alu_result_reg);
    assign m_cond_true     = cond_reg;
    assign m_dest_reg_out  = dest_out_reg;
    assign m_zero_flag     = zf_reg;
    assign m_sign_flag     = sf_reg;
    assign m_overflow_flag = of_reg;

    `Y86_ASSERT_RST(a_reset_state, !aresetn |=> (zf_reg && !sf_reg && !of_reg && !m_valid_reg && !in_valid_reg), "execute stage not cleared by reset")
    `Y86_ASSERT(a_flags_hold, !advance |=> ($stable(zf_reg) && $stable(sf_reg) && $stable(of_reg)), "flags changed without an item moving forward")
    `Y86_ASSERT(a_bubble_out, (advance && bubble_reg) |=> (m_dest_reg_out == y86ex_pkg::REG_NONE && !m_cond_true && m_alu_result == 64'sd0), "bubble produced a live result")
    `Y86_ASSERT(a_cmov_squash, (advance && !bubble_reg && opcode_reg == y86ex_pkg::OP_CMOV && !cond_next) |=> (m_dest_reg_out == y86ex_pkg::REG_NONE), "failed conditional move kept its destination")

endmodule

### test/testbench.sv
// Self-checking testbench for the Y86-64 execute stage: ALU results, flags and condition tests.
module testbench;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [3:0]  func_code;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
        logic [63:0] constant_c;
        logic [3:0]  dest_reg_e;
        logic        is_bubble;
        logic        later_exception;
    } instr_t;

    typedef struct packed {
        logic [63:0] alu_result;
        logic        cond_true;
        logic [3:0]  dest_reg_out;
        logic        zero_flag;
        logic        sign_flag;
        logic        overflow_flag;
    } exec_result_t;

    localparam logic [63:0] WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] WORD_MIN = 64'h8000_0000_0000_0000;
    localparam int          RANDOM_ITEMS = 750;
    localparam int          HOLD_AT_ITEM = 300;
    localparam int          HOLD_CYCLES = 80;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_opcode = '0;
    logic [3:0]         s_func_code = '0;
    logic signed [63:0] s_operand_a = '0;
    logic signed [63:0] s_operand_b = '0;
    logic signed [63:0] s_constant_c = '0;
    logic [3:0]         s_dest_reg_e = '0;
    logic               s_is_bubble = 1'b0;
    logic               s_later_exception = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [63:0] m_alu_result;
    logic               m_cond_true;
    logic [3:0]         m_dest_reg_out;
    logic               m_zero_flag;
    logic               m_sign_flag;
    logic               m_overflow_flag;

    y86_execute_stage DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_func_code       (s_func_code),
        .s_operand_a       (s_operand_a),
        .s_operand_b       (s_operand_b),
        .s_constant_c      (s_constant_c),
        .s_dest_reg_e      (s_dest_reg_e),
        .s_is_bubble       (s_is_bubble),
        .s_later_exception (s_later_exception),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_alu_result      (m_alu_result),
        .m_cond_true       (m_cond_true),
        .m_dest_reg_out    (m_dest_reg_out),
        .m_zero_flag       (m_zero_flag),
        .m_sign_flag       (m_sign_flag),
        .m_overflow_flag   (m_overflow_flag)
    );

    always #2 aclk = ~aclk;

    instr_t       pending_instrs[$];
    exec_result_t expected_results[$];
    instr_t       cur_instr;

    // Predicted condition flags, reset values.
    logic zero_q = 1'b1;
    logic sign_q = 1'b0;
    logic ovf_q  = 1'b0;

    int sent_count = 0;
    int total_items = 0;
    int mismatches = 0;
    int errors = 0;
    int send_gap = 0;
    int send_burst = 0;
    int recv_stall = 0;
    int recv_burst = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    function automatic logic [63:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 64'd0;
            3: return {64{1'b1}};
            4: return 64'd1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Computes the result of one instruction and advances the predicted flags.
    function automatic exec_result_t predict_execute(instr_t it);
        logic [63:0]  alu_a;
        logic [63:0]  alu_b;
        logic [63:0]  sum;
        logic [3:0]   fn;
        logic         lt;
        logic         eq;
        logic         cnd;
        exec_result_t res;
        alu_a = '0;
        alu_b = '0;
        sum = '0;
        if (it.is_bubble) begin
            res.alu_result = '0;
            res.cond_true = 1'b0;
            res.dest_reg_out = y86ex_pkg::REG_NONE;
            res.zero_flag = zero_q;
            res.sign_flag = sign_q;
            res.overflow_flag = ovf_q;
            return res;
        end
        case (it.opcode)
            y86ex_pkg::OP_CMOV, y86ex_pkg::OP_OPQ: alu_a = it.operand_a;
            y86ex_pkg::OP_IRMOV, y86ex_pkg::OP_RMMOV, y86ex_pkg::OP_MRMOV,
            y86ex_pkg::OP_JXX, y86ex_pkg::OP_IADD: alu_a = it.constant_c;
            y86ex_pkg::OP_CALL, y86ex_pkg::OP_PUSH: alu_a = y86ex_pkg::STACK_DOWN;
            y86ex_pkg::OP_RET, y86ex_pkg::OP_POP: alu_a = y86ex_pkg::STACK_UP;
            default: alu_a = '0;
        endcase
        case (it.opcode)
            y86ex_pkg::OP_RMMOV, y86ex_pkg::OP_MRMOV, y86ex_pkg::OP_OPQ,
            y86ex_pkg::OP_CALL, y86ex_pkg::OP_RET, y86ex_pkg::OP_PUSH,
            y86ex_pkg::OP_POP, y86ex_pkg::OP_IADD:
                alu_b = it.operand_b;
            default: alu_b = '0;
        endcase
        fn = (it.opcode == y86ex_pkg::OP_OPQ) ? it.func_code : y86ex_pkg::ALU_ADD;
        case (fn)
            y86ex_pkg::ALU_ADD: sum = alu_b + alu_a;
            y86ex_pkg::ALU_SUB: sum = alu_b - alu_a;
            y86ex_pkg::ALU_AND: sum = alu_b & alu_a;
            y86ex_pkg::ALU_XOR: sum = alu_b ^ alu_a;
            default: sum = '0;
        endcase
        if ((it.opcode == y86ex_pkg::OP_OPQ || it.opcode == y86ex_pkg::OP_IADD)
            && !it.later_exception) begin
            case (fn)
                y86ex_pkg::ALU_ADD:
                    ovf_q = (alu_a[63] == alu_b[63]) && (sum[63] != alu_a[63]);
                y86ex_pkg::ALU_SUB:
                    ovf_q = (alu_a[63] != alu_b[63]) && (sum[63] != alu_b[63]);
                default: ovf_q = 1'b0;
            endcase
            sign_q = sum[63];
            zero_q = (sum == '0);
        end
        lt = sign_q ^ ovf_q;
        eq = zero_q;
        case (it.func_code)
            y86ex_pkg::COND_ALWAYS: cnd = 1'b1;
            y86ex_pkg::COND_LE:     cnd = lt | eq;
            y86ex_pkg::COND_L:      cnd = lt;
            y86ex_pkg::COND_E:      cnd = eq;
            y86ex_pkg::COND_NE:     cnd = !eq;
            y86ex_pkg::COND_GE:     cnd = !lt;
            y86ex_pkg::COND_G:      cnd = !lt && !eq;
            default:                cnd = 1'b0;
        endcase
        res.alu_result = sum;
        res.cond_true = cnd;
        res.dest_reg_out = (it.opcode == y86ex_pkg::OP_CMOV && !cnd) ? y86ex_pkg::REG_NONE
                                                                     : it.dest_reg_e;
        res.zero_flag = zero_q;
        res.sign_flag = sign_q;
        res.overflow_flag = ovf_q;
        return res;
    endfunction

    task automatic queue_instr(input logic [3:0] op, input logic [3:0] fn,
                               input logic [63:0] a, input logic [63:0] b,
                               input logic [63:0] c, input logic [3:0] dst,
                               input logic bubble, input logic lexc);
        instr_t it;
        it.opcode = op;
        it.func_code = fn;
        it.operand_a = a;
        it.operand_b = b;
        it.constant_c = c;
        it.dest_reg_e = dst;
        it.is_bubble = bubble;
        it.later_exception = lexc;
        pending_instrs.insert(pending_instrs.size(), it);
    endtask

    // Driver: offers pending items with random gaps between them.
    always @(posedge aclk) begin : drive_proc
        logic busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(), predict_execute(cur_instr));
                sent_count <= sent_count + 1;
                busy = 1'b0;
                if (send_burst > 0) begin
                    send_burst--;
                    send_gap = 0;
                end else begin
                    send_gap = rand_gap();
                    if ($urandom_range(0, 31) == 0) send_burst = $urandom_range(20, 60);
                end
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_instrs.size() > 0) begin
                    cur_instr = pending_instrs.pop_front();
                    s_opcode <= cur_instr.opcode;
                    s_func_code <= cur_instr.func_code;
                    s_operand_a <= cur_instr.operand_a;
                    s_operand_b <= cur_instr.operand_b;
                    s_constant_c <= cur_instr.constant_c;
                    s_dest_reg_e <= cur_instr.dest_reg_e;
                    s_is_bubble <= cur_instr.is_bubble;
                    s_later_exception <= cur_instr.later_exception;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off partway through, so the stage fills and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (sent_count >= HOLD_AT_ITEM && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each accepted result and drives a randomly stalling ready.
    always @(posedge aclk) begin : monitor_proc
        exec_result_t got;
        exec_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.alu_result = m_alu_result;
                got.cond_true = m_cond_true;
                got.dest_reg_out = m_dest_reg_out;
                got.zero_flag = m_zero_flag;
                got.sign_flag = m_sign_flag;
                got.overflow_flag = m_overflow_flag;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("unexpected result: result=%h cond=%b dst=%0d flags=%b%b%b",
                             got.alu_result, got.cond_true, got.dest_reg_out,
                             got.zero_flag, got.sign_flag, got.overflow_flag);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected result=%h cond=%b dst=%0d zso=%b%b%b",
                                     want.alu_result, want.cond_true, want.dest_reg_out,
                                     want.zero_flag, want.sign_flag, want.overflow_flag);
                            $display("          actual   result=%h cond=%b dst=%0d zso=%b%b%b",
                                     got.alu_result, got.cond_true, got.dest_reg_out,
                                     got.zero_flag, got.sign_flag, got.overflow_flag);
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_burst > 0) begin
                    recv_burst--;
                end else if ($urandom_range(0, 99) < 20) begin
                    recv_stall = rand_gap();
                end else if ($urandom_range(0, 31) == 0) begin
                    recv_burst = $urandom_range(20, 60);
                end
            end
        end
    end

    initial begin : stimulus
        logic [3:0]  op;
        logic [3:0]  fn;
        logic [63:0] a;
        logic [63:0] b;
        int          r;
        // Directed: every opcode, each paired with a different function code.
        for (int i = 0; i < 16; i++) begin
            queue_instr(i[3:0], i[3:0], rand_word(), rand_word(), rand_word(),
                        4'($urandom_range(0, 15)), 1'b0, 1'b0);
        end
        queue_instr(y86ex_pkg::OP_OPQ, y86ex_pkg::ALU_ADD, 64'd1, WORD_MAX, 64'd0, 4'd3,
                    1'b0, 1'b0);
        queue_instr(y86ex_pkg::OP_OPQ, y86ex_pkg::ALU_SUB, 64'd1, WORD_MIN, 64'd0, 4'd4,
                    1'b0, 1'b0);
        queue_instr(y86ex_pkg::OP_OPQ, y86ex_pkg::ALU_AND, {64{1'b1}}, WORD_MIN, 64'd0, 4'd5,
                    1'b0, 1'b0);
        queue_instr(y86ex_pkg::OP_OPQ, y86ex_pkg::ALU_XOR, WORD_MAX, WORD_MAX, 64'd0, 4'd6,
                    1'b0, 1'b0);
        queue_instr(y86ex_pkg::OP_OPQ, 4'd9, WORD_MAX, 64'd5, 64'd0, 4'd7, 1'b0, 1'b0);
        // A later exception keeps the flags; the bubble must ignore everything it carries.
        queue_instr(y86ex_pkg::OP_IADD, y86ex_pkg::ALU_ADD, 64'd0, WORD_MIN, {64{1'b1}}, 4'd8,
                    1'b0, 1'b1);
        queue_instr(y86ex_pkg::OP_CMOV, y86ex_pkg::COND_E, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                    4'd15, 1'b0, 1'b1);
        queue_instr(y86ex_pkg::OP_OPQ, y86ex_pkg::ALU_ADD, WORD_MAX, WORD_MAX, WORD_MAX, 4'd1,
                    1'b1, 1'b1);
        queue_instr(y86ex_pkg::OP_CMOV, y86ex_pkg::COND_G, 64'd0, 64'd0, 64'd0, 4'd0,
                    1'b0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20) op = y86ex_pkg::OP_OPQ;
            else if (r < 35) op = y86ex_pkg::OP_CMOV;
            else if (r < 45) op = y86ex_pkg::OP_IADD;
            else op = 4'($urandom_range(0, 15));
            fn = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(0, 6));
            a = rand_word();
            b = ($urandom_range(0, 9) == 0) ? a : rand_word();
            queue_instr(op, fn, a, b, rand_word(), 4'($urandom_range(0, 15)),
                        1'($urandom_range(0, 9) == 0), 1'($urandom_range(0, 9) == 0));
        end
        total_items = pending_instrs.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        wait (sent_count == total_items);
        wait (expected_results.size() == 0);
        repeat (5) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("** y86_execute_stage: PASSED **");
        end else begin
            $display("** y86_execute_stage: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("** y86_execute_stage: FAILED **");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/y86ex_pkg.sv
hdl/y86_execute_stage.sv
test/testbench.sv
